// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sparse row dot-product block.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/csrspmv_pkg.sv
// Shared constants, types and helper functions of the sparse row dot-product block.
// No dependencies.
`default_nettype none
package csrspmv_pkg;

  localparam int TABLE_DEPTH  = 4096;
  localparam int VECTOR_DEPTH = 65536;
  localparam int TBL_AW = $clog2(TABLE_DEPTH);
  localparam int VEC_AW = $clog2(VECTOR_DEPTH);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [1:0] OP_TABLE_LOAD  = 2'd0;
  localparam logic [1:0] OP_VECTOR_LOAD = 2'd1;
  localparam logic [1:0] OP_NONZERO     = 2'd2;
  localparam logic [1:0] OP_EMPTY_ROW   = 2'd3;

  localparam logic [2:0] INDEX_BYTES_RESET = 3'd1;

  // Default quiet NaN produced by an invalid operation.
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

  typedef struct packed {
    logic        close;
    logic        last;
    logic        err;
    logic [63:0] a;
    logic [63:0] x;
  } qent_t;

  // Unrounded value: mant has its binary point right of bit 107, scaled by 2^exp.
  typedef struct packed {
    logic        force_en;
    logic [63:0] force_val;
    logic        sign;
    logic [13:0] exp;
    logic [107:0] mant;
  } rnd_in_t;

  function automatic logic [6:0] lzc108(input logic [107:0] v);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 108; i++) begin
      if (v[i]) n = 7'(107 - i);
    end
    return n;
  endfunction

  function automatic logic is_nan(input logic [63:0] v);
    return (v[62:52] == 11'h7FF) && (v[51:0] != 52'b0);
  endfunction

  function automatic logic is_inf(input logic [63:0] v);
    return (v[62:52] == 11'h7FF) && (v[51:0] == 52'b0);
  endfunction

  function automatic logic is_zero(input logic [63:0] v);
    return v[62:0] == 63'b0;
  endfunction

  function automatic logic [63:0] quiet(input logic [63:0] v);
    return v | 64'h0008_0000_0000_0000;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/csrspmv_stream_if.sv
// Valid/ready channel interfaces for input items and finished row results.
// No dependencies.
`default_nettype none
interface csrspmv_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] load_address;
  logic [63:0] load_value;
  logic [15:0] column;
  logic [31:0] value_index;
  logic        last_in_row;

  modport source (output valid, op, load_address, load_value, column, value_index,
                  last_in_row, input ready);
  modport sink (input valid, op, load_address, load_value, column, value_index,
                last_in_row, output ready);
endinterface

interface csrspmv_row_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_sum;
  logic [31:0] row_number;
  logic        index_error;

  modport source (output valid, row_sum, row_number, index_error, input ready);
  modport sink (input valid, row_sum, row_number, index_error, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/csrspmv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module csrspmv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/csrspmv_queue.sv
// Short queue between the front end and the arithmetic back end.
// Depends on csrspmv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module csrspmv_queue import csrspmv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  qent_t     push_data,
  input  wire logic pop,
  output qent_t     head,
  output logic      nonempty,
  output logic [QCW-1:0] count
);
  qent_t          mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;

  assign head     = mem[rp];
  assign nonempty = count != '0;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push && !pop, count < QCW'(QDEPTH), "queue overflow")
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, count != '0, "pop from empty queue")
endmodule
`default_nettype wire

// File: hw/rtl/csrspmv_front.sv
// Front end: takes item beats, performs loads, looks up nonzero operands, queues work.
// Depends on csrspmv_pkg, csrspmv_stream_if and csrspmv_ram.
`default_nettype none
module csrspmv_front import csrspmv_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  csrspmv_item_if.sink    item,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata,
  input  wire logic [QCW-1:0] q_count,
  output logic            q_push,
  output qent_t           q_entry
);
  logic [2:0]  index_bytes;
  logic [31:0] mask;
  logic [31:0] vidx;
  logic [31:0] laddr;
  logic [31:0] col;
  logic        accept;
  logic        idx_ok;
  logic        col_ok;
  logic        tbl_we;
  logic        vec_we;
  logic [63:0] tbl_rdata;
  logic [63:0] vec_rdata;
  logic        s1_valid;
  logic        s1_close;
  logic        s1_last;
  logic        s1_err;
  logic        s1_a_zero;
  logic        s1_x_zero;

  always_comb begin
    case (index_bytes)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  // Room for the beat in the lookup stage plus this one.
  assign item.ready = q_count <= QCW'(QDEPTH - 2);
  assign accept     = item.valid && item.ready;
  assign vidx       = item.value_index & mask;
  assign laddr      = {16'b0, item.load_address};
  assign col        = {16'b0, item.column};
  assign idx_ok     = vidx < 32'(TABLE_DEPTH);
  assign col_ok     = col < 32'(VECTOR_DEPTH);
  assign tbl_we     = accept && (item.op == OP_TABLE_LOAD) && (laddr < 32'(TABLE_DEPTH));
  assign vec_we     = accept && (item.op == OP_VECTOR_LOAD) && (laddr < 32'(VECTOR_DEPTH));

  csrspmv_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (laddr[TBL_AW-1:0]),
    .wdata (item.load_value),
    .re    (accept),
    .raddr (vidx[TBL_AW-1:0]),
    .rdata (tbl_rdata)
  );

  csrspmv_ram #(.WIDTH(64), .DEPTH(VECTOR_DEPTH)) u_vector (
    .clk   (clk),
    .we    (vec_we),
    .waddr (laddr[VEC_AW-1:0]),
    .wdata (item.load_value),
    .re    (accept),
    .raddr (col[VEC_AW-1:0]),
    .rdata (vec_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bytes <= INDEX_BYTES_RESET;
      s1_valid    <= 1'b0;
    end else begin
      if (cfg_we) index_bytes <= cfg_wdata;
      s1_valid <= accept && ((item.op == OP_NONZERO) || (item.op == OP_EMPTY_ROW));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_close  <= item.op == OP_EMPTY_ROW;
      s1_last   <= item.last_in_row;
      s1_err    <= !idx_ok;
      s1_a_zero <= !idx_ok;
      s1_x_zero <= !col_ok;
    end
  end

  assign q_push        = s1_valid;
  assign q_entry.close = s1_close;
  assign q_entry.last  = s1_last;
  assign q_entry.err   = s1_err && !s1_close;
  assign q_entry.a     = s1_a_zero ? 64'b0 : tbl_rdata;
  assign q_entry.x     = s1_x_zero ? 64'b0 : vec_rdata;
endmodule
`default_nettype wire

// File: hw/rtl/csrspmv_round.sv
// Three-stage normalize and round-to-nearest-even unit producing an IEEE double.
// Depends on csrspmv_pkg.
`default_nettype none
module csrspmv_round import csrspmv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  rnd_in_t   din,
  output logic      out_valid,
  output logic [63:0] dout
);
  logic        r1_valid;
  rnd_in_t     r1;
  logic [6:0]  r1_lz;
  logic        r2_valid;
  logic        r2_force;
  logic [63:0] r2_fval;
  logic        r2_sign;
  logic [13:0] r2_be;
  logic        r2_zero;
  logic [107:0] r2_n;

  logic [13:0]  shraw;
  logic [6:0]   sh;
  logic [107:0] shifted;
  logic         lost;
  logic [52:0]  mant;
  logic         guard;
  logic         sticky;
  logic         inc;
  logic [10:0]  efield;
  logic [62:0]  packed_mag;
  logic [63:0]  result;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid  <= 1'b0;
      r2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      r1_valid  <= in_valid;
      r2_valid  <= r1_valid;
      out_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    r1       <= din;
    r1_lz    <= lzc108(din.mant);
    r2_force <= r1.force_en;
    r2_fval  <= r1.force_val;
    r2_sign  <= r1.sign;
    r2_zero  <= r1.mant == 108'b0;
    r2_n     <= r1.mant << r1_lz;
    r2_be    <= r1.exp - {7'b0, r1_lz} + 14'd1023;
    dout     <= result;
  end

  always_comb begin
    shraw = 14'd1 - r2_be;
    if ($signed(r2_be) >= 14'sd1) sh = 7'd0;
    else if ($signed(shraw) > 14'sd108) sh = 7'd108;
    else sh = shraw[6:0];
    shifted = r2_n >> sh;
    lost    = |(r2_n & ~({108{1'b1}} << sh));
    mant    = shifted[107:55];
    guard   = shifted[54];
    sticky  = (|shifted[53:0]) | lost;
    inc     = guard && (sticky || mant[0]);
    efield  = ($signed(r2_be) >= 14'sd1) ? r2_be[10:0] : 11'd0;
    // A carry out of the fraction moves into the exponent field, which also
    // turns a subnormal into the smallest normal and the largest finite into infinity.
    packed_mag = {efield, mant[51:0]} + {62'b0, inc};
    if (r2_force) result = r2_fval;
    else if (r2_zero) result = {r2_sign, 63'b0};
    else if ($signed(r2_be) >= 14'sd2047) result = {r2_sign, 11'h7FF, 52'b0};
    else result = {r2_sign, packed_mag};
  end
endmodule
`default_nettype wire

// File: hw/rtl/csrspmv_back.sv
// Back end: multiplies each queued operand pair, adds it to the row sum, emits rows.
// Depends on csrspmv_pkg, csrspmv_stream_if, csrspmv_round and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module csrspmv_back import csrspmv_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    q_valid,
  input  qent_t        q_head,
  output logic         q_pop,
  csrspmv_row_if.source row
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL0 = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MRND = 3'd3;
  localparam logic [2:0] ST_ADD0 = 3'd4;
  localparam logic [2:0] ST_ADD1 = 3'd5;
  localparam logic [2:0] ST_ARND = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0]  state;
  logic [63:0] opa;
  logic [63:0] opb;
  logic        cur_last;
  logic [63:0] acc;
  logic [31:0] rowcnt;
  logic        rowerr;
  logic [63:0] prod;

  logic        out_valid;
  logic [63:0] out_sum;
  logic [31:0] out_num;
  logic        out_err;
  logic        emit;

  // Multiply stage registers.
  logic [53:0] pp_hh;
  logic [52:0] pp_hl;
  logic [52:0] pp_lh;
  logic [51:0] pp_ll;
  logic        m_force;
  logic [63:0] m_fval;
  logic        m_sign;
  logic [13:0] m_exp;

  // Add stage registers.
  logic        s_force;
  logic [63:0] s_fval;
  logic        s_sign;
  logic [13:0] s_exp;
  logic        s_sub;
  logic [55:0] big_al;
  logic [55:0] small_al;

  // Multiply operand decode.
  logic [52:0] ma;
  logic [52:0] mb;
  logic [10:0] ea_eff;
  logic [10:0] eb_eff;
  logic        mul_sign;
  logic        mf;
  logic [63:0] mfv;
  logic [105:0] prod_full;
  logic [53:0]  mid;

  // Add operand decode.
  logic        swap;
  logic [63:0] big;
  logic [63:0] sml;
  logic [10:0] bge;
  logic [10:0] sme;
  logic [10:0] dexp;
  logic [5:0]  dd;
  logic [55:0] ext;
  logic [55:0] shifted;
  logic        lost;
  logic        af;
  logic [63:0] afv;
  logic [56:0] sum;

  logic        rnd_in_valid;
  rnd_in_t     rnd_in;
  logic        rnd_out_valid;
  logic [63:0] rnd_out;

  always_comb begin
    ea_eff   = (opa[62:52] == 11'd0) ? 11'd1 : opa[62:52];
    eb_eff   = (opb[62:52] == 11'd0) ? 11'd1 : opb[62:52];
    ma       = {opa[62:52] != 11'd0, opa[51:0]};
    mb       = {opb[62:52] != 11'd0, opb[51:0]};
    mul_sign = opa[63] ^ opb[63];
    mf       = 1'b1;
    if (is_nan(opa)) mfv = quiet(opa);
    else if (is_nan(opb)) mfv = quiet(opb);
    else if ((is_inf(opa) && is_zero(opb)) || (is_zero(opa) && is_inf(opb))) mfv = DEFAULT_NAN;
    else if (is_inf(opa) || is_inf(opb)) mfv = {mul_sign, 11'h7FF, 52'b0};
    else if (is_zero(opa) || is_zero(opb)) mfv = {mul_sign, 63'b0};
    else begin
      mf  = 1'b0;
      mfv = 64'b0;
    end
  end

  assign mid       = {1'b0, pp_hl} + {1'b0, pp_lh};
  assign prod_full = {pp_hh, 52'b0} + {26'b0, mid, 26'b0} + {54'b0, pp_ll};

  always_comb begin
    swap    = acc[62:0] < prod[62:0];
    big     = swap ? prod : acc;
    sml     = swap ? acc : prod;
    bge     = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
    sme     = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
    dexp    = bge - sme;
    dd      = (dexp > 11'd56) ? 6'd56 : dexp[5:0];
    ext     = {sml[62:52] != 11'd0, sml[51:0], 3'b000};
    shifted = ext >> dd;
    lost    = |(ext & ~({56{1'b1}} << dd));
    af      = 1'b1;
    if (is_nan(acc)) afv = quiet(acc);
    else if (is_nan(prod)) afv = quiet(prod);
    else if (is_inf(acc) && is_inf(prod) && (acc[63] != prod[63])) afv = DEFAULT_NAN;
    else if (is_inf(acc)) afv = acc;
    else if (is_inf(prod)) afv = prod;
    else if (is_zero(acc) && is_zero(prod)) afv = {acc[63] & prod[63], 63'b0};
    else if (is_zero(acc)) afv = prod;
    else if (is_zero(prod)) afv = acc;
    else begin
      af  = 1'b0;
      afv = 64'b0;
    end
  end

  assign sum = s_sub ? ({1'b0, big_al} - {1'b0, small_al})
                     : ({1'b0, big_al} + {1'b0, small_al});

  always_comb begin
    rnd_in_valid = 1'b0;
    rnd_in       = '0;
    if (state == ST_MUL1) begin
      rnd_in_valid       = 1'b1;
      rnd_in.force_en    = m_force;
      rnd_in.force_val   = m_fval;
      rnd_in.sign        = m_sign;
      rnd_in.exp         = m_exp;
      rnd_in.mant        = {prod_full, 2'b00};
    end else if (state == ST_ADD1) begin
      rnd_in_valid       = 1'b1;
      // Exact cancellation rounds to positive zero.
      rnd_in.force_en    = s_force || (sum == 57'b0);
      rnd_in.force_val   = s_force ? s_fval : 64'b0;
      rnd_in.sign        = s_sign;
      rnd_in.exp         = s_exp;
      rnd_in.mant        = {sum, 51'b0};
    end
  end

  csrspmv_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rnd_in_valid),
    .din       (rnd_in),
    .out_valid (rnd_out_valid),
    .dout      (rnd_out)
  );

  assign q_pop = (state == ST_IDLE) && q_valid;
  assign emit  = (state == ST_EMIT) && (!out_valid || row.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      acc       <= 64'b0;
      rowcnt    <= 32'b0;
      rowerr    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (row.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_head.close) state <= ST_EMIT;
            else begin
              rowerr <= rowerr | q_head.err;
              state  <= ST_MUL0;
            end
          end
        end
        ST_MUL0: state <= ST_MUL1;
        ST_MUL1: state <= ST_MRND;
        ST_MRND: if (rnd_out_valid) state <= ST_ADD0;
        ST_ADD0: state <= ST_ADD1;
        ST_ADD1: state <= ST_ARND;
        ST_ARND: begin
          if (rnd_out_valid) begin
            acc   <= rnd_out;
            state <= cur_last ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            rowcnt    <= rowcnt + 32'd1;
            acc       <= 64'b0;
            rowerr    <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      opa      <= q_head.a;
      opb      <= q_head.x;
      cur_last <= q_head.last;
    end
    if (state == ST_MUL0) begin
      pp_hh   <= ma[52:26] * mb[52:26];
      pp_hl   <= ma[52:26] * mb[25:0];
      pp_lh   <= ma[25:0] * mb[52:26];
      pp_ll   <= ma[25:0] * mb[25:0];
      m_force <= mf;
      m_fval  <= mfv;
      m_sign  <= mul_sign;
      m_exp   <= {3'b0, ea_eff} + {3'b0, eb_eff} - 14'd2045;
    end
    if ((state == ST_MRND) && rnd_out_valid) prod <= rnd_out;
    if (state == ST_ADD0) begin
      s_force  <= af;
      s_fval   <= afv;
      s_sign   <= big[63];
      s_sub    <= acc[63] ^ prod[63];
      s_exp    <= {3'b0, bge} - 14'd1022;
      big_al   <= {bge == 11'd0 ? 1'b0 : big[62:52] != 11'd0, big[51:0], 3'b000};
      small_al <= {shifted[55:1], shifted[0] | lost};
    end
    if (emit) begin
      out_sum <= acc;
      out_num <= rowcnt;
      out_err <= rowerr;
    end
  end

  assign row.valid       = out_valid;
  assign row.row_sum     = out_sum;
  assign row.row_number  = out_num;
  assign row.index_error = out_err;

  `ASSERT_IMPLIES(a_rnd_owner, clk, rst, rnd_out_valid, (state == ST_MRND) || (state == ST_ARND), "round result outside a wait state")
  `ASSERT_NEXT(a_emit_clears, clk, rst, emit, (acc == 64'b0) && !rowerr && out_valid, "row state not cleared after emit")
endmodule
`default_nettype wire

// File: hw/rtl/csr_spmv_value_lut_row_dot.sv
// Top level of the sparse row dot-product block: front end, work queue, back end.
// Depends on csrspmv_pkg, csrspmv_stream_if, csrspmv_front, csrspmv_queue, csrspmv_back.
//
// Row-wise sparse matrix-vector product over a table of distinct double values.
// Load beats write the value table or the dense vector; the front accepts a beat every
// cycle while its four-entry queue has room. A nonzero occupies the double-precision
// back end along the serial path multiply, round, add, round through the row
// accumulator, and no new entry is popped until it is done; a row-closing nonzero or
// an empty-row beat then emits the row. Table and vector entries hold no defined
// value until loaded. index_bytes may be written only while the block is idle.
`default_nettype none
module csr_spmv_value_lut_row_dot import csrspmv_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  csrspmv_item_if.sink    item,
  csrspmv_row_if.source   row,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata
);
  logic           q_push;
  qent_t          q_entry;
  logic           q_pop;
  qent_t          q_head;
  logic           q_valid;
  logic [QCW-1:0] q_count;

  csrspmv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  csrspmv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_valid),
    .count     (q_count)
  );

  csrspmv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .row     (row)
  );
endmodule
`default_nettype wire
